// File: sv/scwr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package scwr_pkg;

  localparam logic [11:0] CORE_STATUS_ADDR = 12'd160;
  localparam logic [11:0] JTAG_ADDR        = 12'd116;
  localparam logic [11:0] SLEEP_CTRL_ADDR  = 12'd260;
  localparam logic [11:0] BOOT_ADDR_ADDR   = 12'd4;
  localparam logic [11:0] BYPASS_ADDR      = 12'd112;
  localparam int unsigned JTAG_EXT_SHIFT   = 8;

  localparam logic [3:0]  WORD_SIZE        = 4'd4;
  localparam logic [31:0] EXIT_CODE_MASK   = 32'h7fff_ffff;
  localparam logic [31:0] CAPTURE_START    = 32'h0BBA_ABBA;
  localparam logic [31:0] CAPTURE_STOP     = 32'h0BBA_DEAD;

  typedef enum logic [2:0] {
    KIND_READ  = 3'd0,
    KIND_WRITE = 3'd1,
    KIND_GPIO  = 3'd2,
    KIND_RTC   = 3'd3,
    KIND_JTAG  = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    CAP_NONE  = 2'd0,
    CAP_START = 2'd1,
    CAP_STOP  = 2'd2
  } capture_e;

  typedef enum logic [1:0] {
    WAKE_RISE = 2'd0,
    WAKE_FALL = 2'd1,
    WAKE_HIGH = 2'd2,
    WAKE_LOW  = 2'd3
  } wake_type_e;

  typedef enum logic {
    CFG_POWER_EVENT      = 1'b0,
    CFG_CLOCK_GATE_EVENT = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [2:0]  kind;
    logic [11:0] offset;
    logic [3:0]  size_bytes;
    logic [31:0] wdata;
    logic [31:0] gpio_levels;
    logic        rtc_wakeup;
    logic [31:0] ext_value;
  } in_t;

  typedef struct packed {
    logic        status;
    logic [31:0] rdata;
    logic        stop_request;
    logic [1:0]  capture_cmd;
    logic        confreg_valid;
    logic        bootaddr_valid;
    logic [31:0] out_word;
    logic        wakeup_level;
    logic [1:0]  wake_sequence;
    logic        cluster_reset_n;
    logic        cluster_power_on;
    logic [1:0]  event_flags;
  } out_t;

endpackage

`default_nettype wire

// File: sv/soc_control_wakeup_registers.sv
// Channel   Direction  Handshake                     Payload
// in        input      in_valid_i / in_ready_o       in_word_i  (scwr_pkg::in_t)
// out       output     out_valid_o / out_ready_i     out_word_o (scwr_pkg::out_t)
// cfg       input      cfg_we_i (no wait)            cfg_idx_i, cfg_data_i
//
// Each word is decoded and applied to the register state in the cycle it is
// accepted, and its result is written into a two-entry output buffer.
// One word per cycle is sustained while the buffer is not full; each result is registered into the buffer.
// The buffer keeps the input open while one result waits for out_ready_i.
// Reset clears all state registers and empties the buffer; the block accepts at once.
`timescale 1ns / 1ps
`default_nettype none

module soc_control_wakeup_registers (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire scwr_pkg::in_t in_word_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output scwr_pkg::out_t     out_word_o,
  input  wire logic          cfg_we_i,
  input  wire logic          cfg_idx_i,
  input  wire logic [7:0]    cfg_data_i
);

  logic [7:0]  power_evt_q, clock_gate_evt_q;
  logic [31:0] stat_word_q, stat_word_d;
  logic [31:0] boot_addr_q, boot_addr_d;
  logic [31:0] bypass_q, bypass_d;
  logic        clu_reset_q, clu_reset_d;
  logic        clu_power_q, clu_power_d;
  logic        clk_gate_q, clk_gate_d;
  logic [4:0]  wake_sel_q, wake_sel_d;
  logic [1:0]  wake_type_q, wake_type_d;
  logic        wake_en_q, wake_en_d;
  logic [1:0]  wake_seq_q, wake_seq_d;
  logic [1:0]  boot_kind_q, boot_kind_d;
  logic        last_gpio_q, last_gpio_d;
  logic [31:0] jtag_q, jtag_d;
  logic        wake_q, wake_d;

  scwr_pkg::out_t res;
  scwr_pkg::out_t buf_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     cnt_q;
  logic           in_acc, out_acc;
  logic           is_wr, gpio_cur;
  logic [31:0]    jtag_rd;
  logic [31:0]    sleep_rd;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_word_o  = buf_q[rd_ptr_q];
  assign in_acc      = in_valid_i & in_ready_o;
  assign out_acc     = out_valid_o & out_ready_i;

  assign is_wr    = (in_word_i.kind == scwr_pkg::KIND_WRITE);
  assign gpio_cur = in_word_i.gpio_levels[wake_sel_q];
  assign jtag_rd  = (scwr_pkg::JTAG_EXT_SHIFT >= 32) ? 32'd0
                    : (jtag_q << scwr_pkg::JTAG_EXT_SHIFT);
  assign sleep_rd = {12'd0, boot_kind_q, 2'd0, wake_seq_q, wake_en_q, wake_type_q,
                     wake_sel_q, 6'd0};

  always_comb begin
    stat_word_d   = stat_word_q;
    boot_addr_d   = boot_addr_q;
    bypass_d      = bypass_q;
    clu_reset_d   = clu_reset_q;
    clu_power_d   = clu_power_q;
    clk_gate_d    = clk_gate_q;
    wake_sel_d    = wake_sel_q;
    wake_type_d   = wake_type_q;
    wake_en_d     = wake_en_q;
    wake_seq_d    = wake_seq_q;
    boot_kind_d   = boot_kind_q;
    last_gpio_d   = last_gpio_q;
    jtag_d        = jtag_q;
    wake_d        = wake_q;
    res           = '0;

    if (in_word_i.kind == scwr_pkg::KIND_READ || in_word_i.kind == scwr_pkg::KIND_WRITE) begin
      priority if (in_word_i.size_bytes != scwr_pkg::WORD_SIZE) begin
        res.status = 1'b1;
      end else if (in_word_i.offset == scwr_pkg::CORE_STATUS_ADDR) begin
        if (is_wr) begin
          stat_word_d = in_word_i.wdata;
          priority if (in_word_i.wdata[31]) begin
            res.stop_request = 1'b1;
            res.out_word     = in_word_i.wdata & scwr_pkg::EXIT_CODE_MASK;
          end else if (in_word_i.wdata == scwr_pkg::CAPTURE_START) begin
            res.capture_cmd = scwr_pkg::CAP_START;
          end else if (in_word_i.wdata == scwr_pkg::CAPTURE_STOP) begin
            res.capture_cmd = scwr_pkg::CAP_STOP;
          end else begin
            res.capture_cmd = scwr_pkg::CAP_NONE;
          end
        end else begin
          res.rdata = stat_word_q;
        end
      end else if (in_word_i.offset == scwr_pkg::JTAG_ADDR) begin
        if (is_wr) begin
          res.confreg_valid = 1'b1;
          res.out_word      = in_word_i.wdata;
        end else begin
          res.rdata = jtag_rd;
        end
      end else if (in_word_i.offset == scwr_pkg::SLEEP_CTRL_ADDR) begin
        if (is_wr) begin
          wake_sel_d  = in_word_i.wdata[10:6];
          wake_type_d = in_word_i.wdata[12:11];
          wake_en_d   = in_word_i.wdata[13];
          wake_seq_d  = in_word_i.wdata[15:14];
          boot_kind_d = in_word_i.wdata[19:18];
        end else begin
          wake_d    = 1'b0;
          res.rdata = sleep_rd;
        end
      end else if (in_word_i.offset == scwr_pkg::BOOT_ADDR_ADDR) begin
        if (is_wr) begin
          boot_addr_d        = in_word_i.wdata;
          res.bootaddr_valid = 1'b1;
          res.out_word       = in_word_i.wdata;
        end else begin
          res.rdata = boot_addr_q;
        end
      end else if (in_word_i.offset == scwr_pkg::BYPASS_ADDR) begin
        if (is_wr) begin
          bypass_d            = in_word_i.wdata;
          res.event_flags[0]  = in_word_i.wdata[3] ^ clu_power_q;
          res.event_flags[1]  = in_word_i.wdata[10] ^ clk_gate_q;
          clu_reset_d         = in_word_i.wdata[13];
          clu_power_d         = in_word_i.wdata[3];
          clk_gate_d          = in_word_i.wdata[10];
        end else begin
          res.rdata = bypass_q;
        end
      end else begin
        res.rdata = '0;
      end
    end else if (in_word_i.kind == scwr_pkg::KIND_GPIO) begin
      if (wake_en_q) begin
        last_gpio_d = gpio_cur;
        unique case (scwr_pkg::wake_type_e'(wake_type_q))
          scwr_pkg::WAKE_RISE: if (!last_gpio_q && gpio_cur) wake_d = 1'b1;
          scwr_pkg::WAKE_FALL: if (last_gpio_q && !gpio_cur) wake_d = 1'b1;
          scwr_pkg::WAKE_HIGH: if (gpio_cur) wake_d = 1'b1;
          default:             if (!gpio_cur) wake_d = 1'b1;
        endcase
      end
    end else if (in_word_i.kind == scwr_pkg::KIND_RTC) begin
      if (in_word_i.rtc_wakeup) wake_d = 1'b1;
    end else if (in_word_i.kind == scwr_pkg::KIND_JTAG) begin
      jtag_d = in_word_i.ext_value;
    end

    res.wakeup_level     = wake_d;
    res.wake_sequence    = wake_seq_d;
    res.cluster_reset_n  = ~clu_reset_d;
    res.cluster_power_on = clu_power_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      power_evt_q      <= '0;
      clock_gate_evt_q <= '0;
    end else if (cfg_we_i) begin
      unique case (scwr_pkg::cfg_idx_e'(cfg_idx_i))
        scwr_pkg::CFG_POWER_EVENT:      power_evt_q      <= cfg_data_i;
        scwr_pkg::CFG_CLOCK_GATE_EVENT: clock_gate_evt_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stat_word_q   <= '0;
      boot_addr_q   <= '0;
      bypass_q      <= '0;
      clu_reset_q   <= 1'b0;
      clu_power_q   <= 1'b0;
      clk_gate_q    <= 1'b0;
      wake_sel_q    <= '0;
      wake_type_q   <= '0;
      wake_en_q     <= 1'b0;
      wake_seq_q    <= '0;
      boot_kind_q   <= '0;
      last_gpio_q   <= 1'b0;
      jtag_q        <= '0;
      wake_q        <= 1'b0;
    end else if (in_acc) begin
      stat_word_q   <= stat_word_d;
      boot_addr_q   <= boot_addr_d;
      bypass_q      <= bypass_d;
      clu_reset_q   <= clu_reset_d;
      clu_power_q   <= clu_power_d;
      clk_gate_q    <= clk_gate_d;
      wake_sel_q    <= wake_sel_d;
      wake_type_q   <= wake_type_d;
      wake_en_q     <= wake_en_d;
      wake_seq_q    <= wake_seq_d;
      boot_kind_q   <= boot_kind_d;
      last_gpio_q   <= last_gpio_d;
      jtag_q        <= jtag_d;
      wake_q        <= wake_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      buf_q[wr_ptr_q] <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (in_acc) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (out_acc) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  a_cnt_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("output buffer count out of range");

  a_sleep_read_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_word_i.kind == scwr_pkg::KIND_READ
    && in_word_i.size_bytes == scwr_pkg::WORD_SIZE
    && in_word_i.offset == scwr_pkg::SLEEP_CTRL_ADDR
    && in_word_i.offset != scwr_pkg::CORE_STATUS_ADDR
    && in_word_i.offset != scwr_pkg::JTAG_ADDR |=> !wake_q)
    else $error("sleep control read did not clear the wake flag");

  a_jtag_update : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_word_i.kind == scwr_pkg::KIND_JTAG |=> jtag_q == $past(in_word_i.ext_value))
    else $error("external jtag word not taken");

  a_cfg_power : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && cfg_idx_i == scwr_pkg::CFG_POWER_EVENT |=> power_evt_q == $past(cfg_data_i))
    else $error("power event number not written");

  a_cfg_clock_gate : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && cfg_idx_i == scwr_pkg::CFG_CLOCK_GATE_EVENT
    |=> clock_gate_evt_q == $past(cfg_data_i))
    else $error("clock gate event number not written");

  a_word_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_o)
    else $error("accepted word produced no result");

endmodule

`default_nettype wire
